@@ rtl/gas_sensor_ppm_linearizer_macros.svh @@
// Assertion macros for the checker file of the linearizer.
// Each macro needs clk in scope; the NOW and NEXT ones also rst_n.
`ifndef GAS_SENSOR_PPM_LINEARIZER_MACROS_SVH
`define GAS_SENSOR_PPM_LINEARIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset
`define GSL_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gsl_pkg.sv @@
// Package for the gas sensor ppm linearizer: widths, constants, state type
// and the elaboration-time table of exp2 fraction factors. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsl_pkg;

  // Field and port widths
  localparam int ADC_W        = 12;
  localparam int PPM_W        = 32;
  localparam int R0_W         = 16;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  // Default parameter values
  localparam int SPR_DEF      = 8;
  localparam int ADC_BITS_DEF = 12;

  // Datapath widths
  localparam int DIV_W        = 35;   // filter dividend 4*f + ppm
  localparam int LOG_W        = 23;   // signed log2 difference, Q16
  localparam int CUR_W        = 21;   // one log2 value, Q16
  localparam int T_W          = 28;   // signed exponent, Q19
  localparam int FRAC_EXP     = 19;

  // Arithmetic constants
  localparam logic signed [T_W-1:0] T_OFFSET = 28'sd6262510;   // bias + 8.0 in Q19
  localparam logic signed [T_W-1:0] T_SAT    = 28'sd16777216;  // 32.0 in Q19
  localparam logic [PPM_W-1:0] DIGITAL_PPM   = 32'd256000;
  localparam logic [31:0] CLAMP_N            = 32'd421120;
  localparam logic [31:0] CLAMP_MUL          = 32'd330;
  localparam logic [31:0] N_SCALE            = 32'd1280;
  localparam int FILT_DIVR                   = 5;

  // Register map and reset values
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_R0   = 1'b1;
  localparam logic MODE_RESET = 1'b1;
  localparam logic [R0_W-1:0] R0_RESET = 16'd1700;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_PREP,
    ST_NORM,
    ST_SQR,
    ST_EXPT,
    ST_EXP,
    ST_SHIFT,
    ST_FILT_LOAD,
    ST_FILT_DIV,
    ST_DONE
  } gsl_state_t;

  typedef logic [FRAC_EXP-1:0][31:0] fact_tbl_t;

  // 2^(2^-k) in Q30 for k = 1..FRAC_EXP, by repeated truncating square roots
  function automatic fact_tbl_t build_fact();
    fact_tbl_t  tbl;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_q;
    s = 64'd1 << 31;
    for (int k = 0; k < FRAC_EXP; k++) begin
      v     = s << 30;
      res   = 64'd0;
      bit_q = 64'd1 << 62;
      while (bit_q > v) bit_q = bit_q >> 2;
      while (bit_q != 64'd0) begin
        if (v >= res + bit_q) begin
          v   = v - (res + bit_q);
          res = (res >> 1) + bit_q;
        end else begin
          res = res >> 1;
        end
        bit_q = bit_q >> 2;
      end
      s      = res;
      tbl[k] = s[31:0];
    end
    return tbl;
  endfunction

  localparam fact_tbl_t EXP_FACT = build_fact();

endpackage

`default_nettype wire

@@ rtl/gsl_if.sv @@
// Valid/ready channel interfaces for the linearizer's sample and result words.
// Depends on gsl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gsl_in_if;
  logic                       valid;
  logic                       ready;
  logic [gsl_pkg::ADC_W-1:0]  adc_sample;
  logic                       alarm_pin;
  modport source (output valid, adc_sample, alarm_pin, input ready);
  modport sink   (input valid, adc_sample, alarm_pin, output ready);
endinterface

interface gsl_out_if;
  logic                       valid;
  logic                       ready;
  logic [gsl_pkg::PPM_W-1:0]  ppm_q8;
  logic [gsl_pkg::ADC_W-1:0]  average_adc;
  logic                       saturated;
  modport source (output valid, ppm_q8, average_adc, saturated, input ready);
  modport sink   (input valid, ppm_q8, average_adc, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/gas_sensor_ppm_linearizer.sv @@
// Digital mode: one result per sample word, registered after acceptance.
// Analog mode: the last sample of a group starts a serial sequence of two
// 35-step bit-serial divisions, two log2 passes of up to 30 normalize shifts
// and 16 squarings, and 19 exp2 product steps; saturation or zero skips some.
// One word is in work at a time; the output register frees the input side.
// Synchronous active-low reset restores the config, group and filter state.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_ppm_linearizer #(
  parameter int SAMPLES_PER_READING = gsl_pkg::SPR_DEF,
  parameter int ADC_BITS            = gsl_pkg::ADC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gsl_in_if.sink                      in_ch,
  gsl_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsl_pkg::CFG_AW-1:0]  paddr,
  input  logic [gsl_pkg::CFG_DW-1:0]  pwdata,
  output logic [gsl_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import gsl_pkg::*;

  localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
  localparam int SUM_W    = ADC_W + CNT_W;
  localparam int DIVR_MAX = (SAMPLES_PER_READING > FILT_DIVR) ? SAMPLES_PER_READING
                                                              : FILT_DIVR;
  localparam int REM_W    = $clog2(DIVR_MAX + 1) + 1;
  localparam logic [31:0] FULL = 32'd1 << ADC_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_READING - 1);
  localparam logic [REM_W-1:0] SPR_DIVR = REM_W'(SAMPLES_PER_READING);
  localparam logic [REM_W-1:0] FLT_DIVR = REM_W'(FILT_DIVR);

  gsl_state_t state_r, state_nxt;

  logic                mode_r, mode_nxt;
  logic [R0_W-1:0]     r0_r, r0_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PPM_W-1:0]    filt_r, filt_nxt;
  logic [ADC_W-1:0]    avg_r, avg_nxt;
  logic [DIV_W-1:0]    dvd_r, dvd_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [5:0]          step_r, step_nxt;
  logic [31:0]         y_r, y_nxt;
  logic [31:0]         dsav_r, dsav_nxt;
  logic                second_r, second_nxt;
  logic [CUR_W-1:0]    cur_r, cur_nxt;
  logic signed [LOG_W-1:0] l_r, l_nxt;
  logic [23:0]         t_r, t_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [PPM_W-1:0]    ppm_r, ppm_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PPM_W-1:0]    out_ppm_r, out_ppm_nxt;
  logic [ADC_W-1:0]    out_avg_r, out_avg_nxt;
  logic                out_sat_r, out_sat_nxt;

  logic                in_acc;
  logic                slot_free;
  logic                cfg_wr;
  logic [SUM_W-1:0]    sum_tot;
  logic [REM_W:0]      div_sh;
  logic [REM_W-1:0]    divr;
  logic                div_ge;
  logic [DIV_W-1:0]    div_q;
  logic [REM_W-1:0]    div_rem;
  logic [31:0]         r0_eff;
  logic [63:0]         sq_prod;
  logic [31:0]         sq_p;
  logic [CUR_W-1:0]    cur_upd;
  logic signed [T_W-1:0] l_ext;
  logic signed [T_W-1:0] t_val;
  logic [63:0]         exp_prod;
  logic [63:0]         shifted;

  // Handshake and register port
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && slot_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = psel && penable && pwrite;
  assign pready       = 1'b1;
  assign prdata       = (paddr[CFG_AW-1] == REG_MODE) ? CFG_DW'(mode_r) : CFG_DW'(r0_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ppm_q8      = out_ppm_r;
  assign out_ch.average_adc = out_avg_r;
  assign out_ch.saturated   = out_sat_r;

  // Shared datapath pieces
  assign sum_tot  = sum_r + SUM_W'(in_ch.adc_sample);
  assign divr     = (state_r == ST_AVG_DIV) ? SPR_DIVR : FLT_DIVR;
  assign div_sh   = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge   = div_sh >= {1'b0, divr};
  assign div_rem  = div_ge ? REM_W'(div_sh - {1'b0, divr}) : div_sh[REM_W-1:0];
  assign div_q    = {dvd_r[DIV_W-2:0], div_ge};
  assign r0_eff   = (r0_r == '0) ? 32'd1 : 32'(r0_r);
  assign sq_prod  = 64'(y_r) * 64'(y_r);
  assign sq_p     = sq_prod[61:30];
  assign cur_upd  = sq_p[31] ? (cur_r | (CUR_W'(1) << (4'd15 - step_r[3:0]))) : cur_r;
  assign l_ext    = {{(T_W-LOG_W){l_r[LOG_W-1]}}, l_r};
  assign t_val    = T_OFFSET - ((l_ext <<< 4) + (l_ext <<< 3) + l_ext);
  assign exp_prod = 64'(acc_r) * 64'(EXP_FACT[step_r[4:0]]);
  assign shifted  = 64'(acc_r) << t_r[23:19];

  // Next state and datapath sequencing
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    r0_nxt        = r0_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    filt_nxt      = filt_r;
    avg_nxt       = avg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    y_nxt         = y_r;
    dsav_nxt      = dsav_r;
    second_nxt    = second_r;
    cur_nxt       = cur_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    ppm_nxt       = ppm_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ppm_nxt   = out_ppm_r;
    out_avg_nxt   = out_avg_r;
    out_sat_nxt   = out_sat_r;

    // Register writes
    if (cfg_wr) begin
      if (paddr[CFG_AW-1] == REG_MODE) begin
        mode_nxt = pwdata[0];
      end else begin
        r0_nxt = pwdata[R0_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!mode_r) begin
            out_valid_nxt = 1'b1;
            out_ppm_nxt   = in_ch.alarm_pin ? '0 : DIGITAL_PPM;
            out_avg_nxt   = '0;
            out_sat_nxt   = 1'b0;
          end else if (cnt_r == CNT_LAST) begin
            dvd_nxt   = DIV_W'(sum_tot);
            rem_nxt   = '0;
            step_nxt  = '0;
            sum_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_AVG_DIV;
          end else begin
            sum_nxt = sum_tot;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_AVG_DIV: begin
        dvd_nxt  = div_q;
        rem_nxt  = div_rem;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(DIV_W - 1)) begin
          avg_nxt   = div_q[ADC_W-1:0];
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // Form ratio numerator and denominator, clamp low voltage, saturate at full
        step_nxt   = '0;
        second_nxt = 1'b0;
        if (32'(avg_r) * CLAMP_MUL < FULL) begin
          y_nxt     = CLAMP_N;
          dsav_nxt  = r0_eff;
          state_nxt = ST_NORM;
        end else if (32'(avg_r) >= FULL) begin
          ppm_nxt   = '1;
          sat_nxt   = 1'b1;
          state_nxt = ST_FILT_LOAD;
        end else begin
          y_nxt     = N_SCALE * (FULL - 32'(avg_r));
          dsav_nxt  = 32'(avg_r) * r0_eff;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // Shift up one bit a cycle until the leading one reaches bit 30
        if (y_r[30]) begin
          cur_nxt   = {5'(6'd30 - step_r), 16'd0};
          step_nxt  = '0;
          state_nxt = ST_SQR;
        end else begin
          y_nxt    = y_r << 1;
          step_nxt = step_r + 6'd1;
        end
      end
      ST_SQR: begin
        // One fraction bit per squaring
        y_nxt    = sq_p[31] ? {1'b0, sq_p[31:1]} : sq_p;
        cur_nxt  = cur_upd;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd15) begin
          step_nxt = '0;
          if (!second_r) begin
            l_nxt      = $signed(LOG_W'(cur_upd));
            y_nxt      = dsav_r;
            second_nxt = 1'b1;
            state_nxt  = ST_NORM;
          end else begin
            l_nxt     = l_r - $signed(LOG_W'(cur_upd));
            state_nxt = ST_EXPT;
          end
        end
      end
      ST_EXPT: begin
        acc_nxt  = 32'd1 << 30;
        step_nxt = '0;
        if (t_val >= T_SAT) begin
          ppm_nxt   = '1;
          sat_nxt   = 1'b1;
          state_nxt = ST_FILT_LOAD;
        end else if (t_val[T_W-1]) begin
          ppm_nxt   = '0;
          sat_nxt   = 1'b0;
          state_nxt = ST_FILT_LOAD;
        end else begin
          t_nxt     = t_val[23:0];
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        // Fraction bits from the top, one factor per cycle
        if (t_r[FRAC_EXP-1]) begin
          acc_nxt = exp_prod[61:30];
        end
        t_nxt    = {t_r[23:19], t_r[FRAC_EXP-2:0], 1'b0};
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(FRAC_EXP - 1)) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        ppm_nxt   = shifted[61:30];
        sat_nxt   = 1'b0;
        state_nxt = ST_FILT_LOAD;
      end
      ST_FILT_LOAD: begin
        dvd_nxt   = {1'b0, filt_r, 2'b00} + DIV_W'(ppm_r);
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_FILT_DIV;
      end
      ST_FILT_DIV: begin
        dvd_nxt  = div_q;
        rem_nxt  = div_rem;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(DIV_W - 1)) begin
          filt_nxt  = div_q[PPM_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ppm_nxt   = filt_r;
          out_avg_nxt   = avg_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_RESET;
      r0_r        <= R0_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      r0_r        <= r0_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    avg_r     <= avg_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    y_r       <= y_nxt;
    dsav_r    <= dsav_nxt;
    second_r  <= second_nxt;
    cur_r     <= cur_nxt;
    l_r       <= l_nxt;
    t_r       <= t_nxt;
    acc_r     <= acc_nxt;
    ppm_r     <= ppm_nxt;
    sat_r     <= sat_nxt;
    out_ppm_r <= out_ppm_nxt;
    out_avg_r <= out_avg_nxt;
    out_sat_r <= out_sat_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/gsl_checker.sv @@
// Port-level checker for the linearizer, bound to the top level.
// Depends on gsl_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "gas_sensor_ppm_linearizer_macros.svh"

module gsl_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gsl_pkg::PPM_W-1:0]   out_ppm_q8,
  input logic [gsl_pkg::ADC_W-1:0]   out_average_adc,
  input logic                        out_saturated
);
  import gsl_pkg::*;

  // A stalled result word holds its payload
  `GSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ppm_q8) && $stable(out_average_adc) && $stable(out_saturated), "result word changed while stalled")

  // A stalled output blocks new sample words
  `GSL_ASSERT_NOW(a_in_block, out_valid && !out_ready, !in_ready, "input open while output stalled")

  // Saturation only comes from a nonzero analog average
  `GSL_ASSERT_NOW(a_sat_avg, out_valid && out_saturated, out_average_adc != '0, "saturated word with zero average")

  // Reset empties the output register
  `GSL_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid after reset")

endmodule

bind gas_sensor_ppm_linearizer gsl_port_checker u_gsl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ppm_q8      (out_ch.ppm_q8),
  .out_average_adc (out_ch.average_adc),
  .out_saturated   (out_ch.saturated)
);

`default_nettype wire
